// ===== rtl/bsm_pkg.sv =====
// Package for the binary search membership unit.
// Holds widths, codes and the command/status structs; no dependencies.
package bsm_pkg;

   localparam int VALUE_W         = 32;
   localparam int INDEX_W         = 7;
   localparam int LEN_W           = 8;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 2;
   localparam int TABLE_DEPTH_DEF = 128;

   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] REG_TABLE_LENGTH = CSR_ADDR_W'(0);

   typedef struct packed {
      logic write;
      logic start;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic more;
   } status_type;

endpackage

// ===== rtl/bsm_if.sv =====
// Item channel interfaces for the binary search membership unit.
// Depends on bsm_pkg for field widths.
interface bsm_req_if;
   logic                               valid;
   logic                               ready;
   logic                               func;
   logic [bsm_pkg::INDEX_W-1:0]        entry_index;
   logic signed [bsm_pkg::VALUE_W-1:0] value;

   modport source (output valid, output func, output entry_index, output value,
                   input ready);
   modport sink   (input valid, input func, input entry_index, input value,
                   output ready);
endinterface

interface bsm_rsp_if;
   logic valid;
   logic ready;
   logic found;

   modport source (output valid, output found, input ready);
   modport sink   (input valid, input found, output ready);
endinterface

// ===== rtl/bsm_csr.sv =====
// APB register block: holds table_length.
// Depends on bsm_pkg.
module bsm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bsm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bsm_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bsm_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready,
   output logic [bsm_pkg::LEN_W-1:0]         table_length
);
   import bsm_pkg::*;

   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic             wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel & penable & pwrite & (paddr == REG_TABLE_LENGTH);

   always_comb begin
      len_in = len_ff;
      if (wr_hit) begin
         len_in = pwdata[LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == REG_TABLE_LENGTH) begin
         prdata = CSR_DATA_W'(len_ff);
      end
   end

   assign table_length = len_ff;

endmodule

// ===== rtl/bsm_datapath.sv =====
// Datapath: sorted table memory, search bounds, key and probe compare.
// Depends on bsm_pkg; driven by bsm_ctrl through cmd/status structs.
module bsm_datapath #(
   parameter int TABLE_DEPTH = bsm_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  bsm_pkg::cmd_type                  cmd,
   output bsm_pkg::status_type               status,
   input  logic [bsm_pkg::INDEX_W-1:0]       entry_index,
   input  logic signed [bsm_pkg::VALUE_W-1:0] value,
   input  logic [bsm_pkg::LEN_W-1:0]         table_length
);
   import bsm_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;

   logic signed [VALUE_W-1:0] mem [0:TABLE_DEPTH-1];
   logic signed [VALUE_W-1:0] rdata_ff;
   logic signed [VALUE_W-1:0] key_ff;
   logic [AW-1:0]             mid_ff;
   logic [CW-1:0]             lo_ff;
   logic [CW-1:0]             hip1_ff;

   logic [CW-1:0]             n_sat;
   logic [CW-1:0]             lo_in;
   logic [CW-1:0]             hip1_in;
   logic [CW-1:0]             span;
   logic [CW-1:0]             mid_w;
   logic [CW-1:0]             mid_ext;
   logic [AW-1:0]             rd_addr;
   logic                      rd_en;
   logic [IW-1:0]             idx_ext;
   logic                      wr_en;
   logic                      gt;

   assign idx_ext = IW'(entry_index);
   assign wr_en   = cmd.write & (int'(entry_index) < TABLE_DEPTH);

   always_comb begin
      if (int'(table_length) > TABLE_DEPTH) begin
         n_sat = CW'(TABLE_DEPTH);
      end else begin
         n_sat = CW'(table_length);
      end
   end

   assign mid_ext = CW'(mid_ff);
   assign gt      = rdata_ff > key_ff;

   // next bounds: fresh on start, narrowed around the last probe otherwise
   always_comb begin
      lo_in   = lo_ff;
      hip1_in = hip1_ff;
      if (cmd.start) begin
         lo_in   = '0;
         hip1_in = n_sat;
      end else if (gt) begin
         hip1_in = mid_ext;
      end else begin
         lo_in = mid_ext + CW'(1);
      end
   end

   assign span    = hip1_in - lo_in - CW'(1);
   assign mid_w   = lo_in + (span >> 1);
   assign rd_addr = mid_w[AW-1:0];

   assign status.more = lo_in < hip1_in;
   assign status.hit  = rdata_ff == key_ff;
   assign rd_en       = (cmd.start | cmd.step) & status.more;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ext[AW-1:0]] <= value;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
         mid_ff   <= rd_addr;
      end
      if (cmd.start | cmd.step) begin
         lo_ff   <= lo_in;
         hip1_ff <= hip1_in;
      end
      if (cmd.start) begin
         key_ff <= value;
      end
   end

endmodule

// ===== rtl/bsm_ctrl.sv =====
// Controller: accepts items, sequences the probes and holds the result register.
// Depends on bsm_pkg; steers bsm_datapath through cmd/status structs.
module bsm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_found,
   output bsm_pkg::cmd_type    cmd,
   input  bsm_pkg::status_type status
);
   import bsm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PROBE = 3'b010,
      ST_DONE  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      found_ff, found_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_found_ff, rsp_found_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   always_comb begin
      state_in     = state_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      cmd          = '0;
      if (rsp_valid_ff & rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_WRITE) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  found_in  = 1'b0;
                  state_in  = status.more ? ST_PROBE : ST_DONE;
               end
            end
         end
         ST_PROBE: begin
            if (status.hit) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               if (!status.more) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff | rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

endmodule

// ===== rtl/binary_search_membership_unit.sv =====
// Binary search membership unit: a table of signed 32-bit entries in ascending
// order, filled by write items and searched by search items. A write item gives
// no result. A search item starts its first probe in the accept cycle, if any
// entry is in use, and then makes one probe per cycle, limited by the single
// read port of the table memory; it takes up to ceil(log2(n+1)) probes for n
// entries in use (8 for 128), then finishes and loads the result register once
// the previous result has left it. A new item is taken while a previous result
// still waits in the output register. The table has no reset: every entry
// below table_length must be written before a search reads it. table_length
// is set over the APB port at byte address 0.
// Depends on bsm_pkg, bsm_if, bsm_csr, bsm_ctrl and bsm_datapath.
module binary_search_membership_unit #(
   parameter int TABLE_DEPTH = bsm_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   bsm_req_if.sink                           req_ch,
   bsm_rsp_if.source                         rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [bsm_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bsm_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bsm_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import bsm_pkg::*;

   cmd_type          cmd;
   status_type       status;
   logic [LEN_W-1:0] table_length;

   bsm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .table_length (table_length)
   );

   bsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_func  (req_ch.func),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_found (rsp_ch.found),
      .cmd       (cmd),
      .status    (status)
   );

   bsm_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .entry_index  (req_ch.entry_index),
      .value        (req_ch.value),
      .table_length (table_length)
   );

endmodule

// ===== tb/sv/bsm_membership_checker.sv =====
`timescale 1ns / 100ps
// Checker for the binary search membership unit: mirrors the entry table and
// table_length, predicts the found flag of every search item and checks results.
// Depends on bsm_pkg and the item channel interfaces in bsm_if.
module bsm_membership_checker #(
   parameter int TABLE_DEPTH = bsm_pkg::TABLE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   bsm_req_if                             req_mon,
   bsm_rsp_if                             rsp_mon,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic                           pready,
   input  logic [bsm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bsm_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [bsm_pkg::CSR_DATA_W-1:0] prdata,
   output int                             error_count,
   output int                             pending_results,
   output int                             found_count,
   output int                             missing_count
);
   import bsm_pkg::*;

   logic signed [VALUE_W-1:0] table_mirror [TABLE_DEPTH];
   logic [LEN_W-1:0]          length_mirror;
   bit                        found_expected [$];
   int                        errors;
   int                        found_tally;
   int                        missing_tally;

   function automatic bit key_in_table(logic signed [VALUE_W-1:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = ((int'(length_mirror) > TABLE_DEPTH) ? TABLE_DEPTH : int'(length_mirror)) - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (table_mirror[mid] == key)
            return 1'b1;
         if (table_mirror[mid] > key)
            hi = mid - 1;
         else
            lo = mid + 1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin : check_items
      bit expected;
      if (reset) begin
         found_expected.delete();
         length_mirror = '0;
         errors        = 0;
         found_tally   = 0;
         missing_tally = 0;
      end else begin
         // a result always belongs to an earlier search, so pop before pushing
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (found_expected.size() == 0) begin
               $error("found: expected no result, actual %0b", rsp_mon.found);
               errors++;
            end else begin
               expected = found_expected.pop_front();
               if (rsp_mon.found !== expected) begin
                  $error("found: expected %0b, actual %0b", expected, rsp_mon.found);
                  errors++;
               end
               if (expected)
                  found_tally++;
               else
                  missing_tally++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == FUNC_WRITE) begin
               if (int'(req_mon.entry_index) < TABLE_DEPTH)
                  table_mirror[req_mon.entry_index] = req_mon.value;
            end else begin
               found_expected.push_back(key_in_table(req_mon.value));
            end
         end
         if (psel && penable && pready && paddr == REG_TABLE_LENGTH) begin
            if (pwrite) begin
               length_mirror = pwdata[LEN_W-1:0];
            end else if (prdata[LEN_W-1:0] !== length_mirror) begin
               $error("table_length: expected %0d, actual %0d", length_mirror,
                      prdata[LEN_W-1:0]);
               errors++;
            end
         end
      end
      error_count     <= errors;
      pending_results <= found_expected.size();
      found_count     <= found_tally;
      missing_count   <= missing_tally;
   end

endmodule

// ===== tb/sv/binary_search_membership_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the binary search membership unit testbench: clock, reset, item and
// register stimulus, watchdog and verdict. Depends on bsm_pkg, bsm_if, the unit
// and bsm_membership_checker, which does all the checking.
module binary_search_membership_unit_tb;
   import bsm_pkg::*;

   typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_ALWAYS} idle_mode_type;

   localparam int TABLE_DEPTH   = TABLE_DEPTH_DEF;
   localparam int ITEM_TARGET   = 1550;
   localparam int PHASE_ITEMS   = 70;
   localparam int MAX_GAP       = 19;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 2000;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    error_count;
   int                    pending_results;
   int                    found_count;
   int                    missing_count;

   bsm_req_if req_ch ();
   bsm_rsp_if rsp_ch ();

   logic signed [VALUE_W-1:0] entry_shadow [TABLE_DEPTH];
   bit                        entry_written [TABLE_DEPTH];
   int                        active_entries = 0;
   int                        items_sent = 0;
   int                        settings_made = 0;
   idle_mode_type             req_idle = IDLE_SOME;
   idle_mode_type             rsp_idle = IDLE_SOME;
   int                        hold_asked = 0;
   int                        hold_given = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   binary_search_membership_unit #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   bsm_membership_checker #(.TABLE_DEPTH(TABLE_DEPTH)) membership_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .error_count     (error_count),
      .pending_results (pending_results),
      .found_count     (found_count),
      .missing_count   (missing_count)
   );

   function automatic int draw_gap(idle_mode_type mode);
      case (mode)
         IDLE_NONE: return 0;
         IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
         default:   return $urandom_range(0, MAX_GAP);
      endcase
   endfunction

   function automatic longint rand_below(longint span);
      return longint'({$urandom, $urandom} % span);
   endfunction

   task automatic send_item(logic func, logic [INDEX_W-1:0] idx,
                            logic signed [VALUE_W-1:0] val);
      int gap;
      gap = draw_gap(req_idle);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= func;
      req_ch.entry_index <= idx;
      req_ch.value       <= val;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      if (func == FUNC_WRITE) begin
         entry_shadow[idx]  = val;
         entry_written[idx] = 1'b1;
      end
      items_sent++;
   endtask

   task automatic look_up(logic signed [VALUE_W-1:0] key);
      send_item(FUNC_SEARCH, INDEX_W'($urandom), key);
   endtask

   // drop valid, wait for every search result, then cover a trailing write
   task automatic wait_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(logic write, logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= REG_TABLE_LENGTH;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_table_length(int len);
      wait_until_drained();
      // upper bits are junk on purpose, the register keeps only its own width
      csr_access(1'b1, {(CSR_DATA_W-LEN_W)'($urandom), LEN_W'(len)});
      @(posedge clock);
      csr_access(1'b0, '0);
      active_entries = (len > TABLE_DEPTH) ? TABLE_DEPTH : len;
      settings_made++;
   endtask

   // rewrite entries 0..n-1, ascending unless told otherwise
   task automatic fill_table(int n, bit ordered);
      longint                    step_max;
      longint                    level;
      logic signed [VALUE_W-1:0] val;
      bit                        dense;
      dense    = ($urandom_range(0, 3) == 0);
      step_max = dense ? 64'sd3 : (64'sd1 <<< 33) / (n + 1);
      if ($urandom_range(0, 3) == 0)
         level = longint'(VALUE_MIN);
      else if (dense)
         level = longint'($signed($urandom));
      else
         level = longint'(VALUE_MIN) + rand_below(step_max / 2 + 1);
      for (int i = 0; i < n; i++) begin
         if (ordered) begin
            if (i == n - 1 && $urandom_range(0, 3) == 0)
               level = longint'(VALUE_MAX);
            if (level > VALUE_MAX)
               level = longint'(VALUE_MAX);
            val   = level[VALUE_W-1:0];
            level = level + rand_below(step_max + 1);
         end else begin
            val = $urandom;
         end
         send_item(FUNC_WRITE, INDEX_W'(i), val);
      end
   endtask

   initial begin : stimulus
      int                        len;
      int                        n;
      int                        pick;
      int                        sel;
      int                        idx;
      longint                    lo;
      longint                    hi;
      logic signed [VALUE_W-1:0] key;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.func        <= FUNC_WRITE;
      req_ch.entry_index <= '0;
      req_ch.value       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table after reset
      look_up('0);
      look_up(VALUE_MIN);
      // one entry
      send_item(FUNC_WRITE, '0, 32'sd5);
      set_table_length(1);
      look_up(32'sd5);
      look_up(32'sd4);
      look_up(32'sd6);
      // extremes of the value range
      send_item(FUNC_WRITE, INDEX_W'(0), VALUE_MIN);
      send_item(FUNC_WRITE, INDEX_W'(1), '0);
      send_item(FUNC_WRITE, INDEX_W'(2), VALUE_MAX);
      set_table_length(3);
      look_up(VALUE_MIN);
      look_up(VALUE_MAX);
      look_up('0);
      look_up(-32'sd1);
      look_up(32'sd1);
      look_up(VALUE_MIN + 32'sd1);
      // unsorted table: 7 sits off the probe path
      send_item(FUNC_WRITE, INDEX_W'(0), 32'sd7);
      send_item(FUNC_WRITE, INDEX_W'(1), 32'sd3);
      send_item(FUNC_WRITE, INDEX_W'(2), 32'sd9);
      look_up(32'sd7);
      look_up(32'sd9);
      // top index, outside the entries in use
      send_item(FUNC_WRITE, INDEX_W'(TABLE_DEPTH - 1), 32'sd42);
      look_up(32'sd42);

      for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
         case (phase)
            0: len = TABLE_DEPTH;
            1: len = (1 << LEN_W) - 1;
            2: len = 0;
            3: len = 1;
            default: begin
               sel = $urandom_range(0, 9);
               if (sel == 0)
                  len = 0;
               else if (sel == 1)
                  len = $urandom_range(TABLE_DEPTH, (1 << LEN_W) - 1);
               else if (sel < 5)
                  len = $urandom_range(1, 8);
               else if (sel < 8)
                  len = $urandom_range(9, 40);
               else
                  len = $urandom_range(41, TABLE_DEPTH - 1);
            end
         endcase
         set_table_length(len);
         req_idle = (phase == 0) ? IDLE_NONE : idle_mode_type'($urandom_range(0, 2));
         rsp_idle = idle_mode_type'($urandom_range(0, 2));
         n = active_entries;
         fill_table(n, !(phase >= 4 && $urandom_range(0, 5) == 0));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // back-pressure long enough to fill the unit while items keep coming
            if (phase == 0 && k == 8)
               hold_asked++;
            pick = $urandom_range(0, 99);
            sel  = $urandom_range(0, 99);
            if (pick < 80) begin
               if (n > 0 && sel < 45) begin
                  key = entry_shadow[$urandom_range(0, n - 1)];
               end else if (n > 0 && sel < 65) begin
                  key = entry_shadow[$urandom_range(0, n - 1)] +
                        ($urandom_range(0, 1) ? 1 : -1);
               end else if (sel < 75) begin
                  case ($urandom_range(0, 3))
                     0: key = VALUE_MIN;
                     1: key = VALUE_MAX;
                     2: key = '0;
                     default: key = -32'sd1;
                  endcase
               end else if (sel < 85) begin
                  idx = $urandom_range(0, TABLE_DEPTH - 1);
                  key = entry_written[idx] ? entry_shadow[idx] : $urandom;
               end else begin
                  key = $urandom;
               end
               look_up(key);
            end else begin
               if (n > 0 && sel < 60) begin
                  // keeps the entries in order
                  idx = $urandom_range(0, n - 1);
                  lo  = (idx == 0) ? longint'(VALUE_MIN) : longint'(entry_shadow[idx - 1]);
                  hi  = (idx == n - 1) ? longint'(VALUE_MAX) : longint'(entry_shadow[idx + 1]);
                  if (hi < lo)
                     hi = lo;
                  lo  = lo + rand_below(hi - lo + 1);
                  key = lo[VALUE_W-1:0];
               end else begin
                  if (n < TABLE_DEPTH && sel < 80)
                     idx = $urandom_range(n, TABLE_DEPTH - 1);
                  else
                     idx = $urandom_range(0, TABLE_DEPTH - 1);
                  key = $urandom;
               end
               send_item(FUNC_WRITE, INDEX_W'(idx), key);
            end
         end
      end

      wait_until_drained();
      $display("Run covered %0d items over %0d table_length settings, 0, 1, 128 and 255 included;",
               items_sent, settings_made);
      $display("%0d searches found their key and %0d did not.", found_count, missing_count);
      if (error_count == 0)
         $display("binary_search_membership_unit_tb: clean");
      else
         $display("binary_search_membership_unit_tb: errors");
      $finish;
   end

   initial begin : result_sink
      int gap;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_gap(rsp_idle);
         if (hold_given < hold_asked) begin
            gap = HOLD_CYCLES;
            hold_given++;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("Timed out after %0d cycles without an accepted item.", STALL_LIMIT);
      $display("binary_search_membership_unit_tb: errors");
      $finish;
   end

endmodule
